// ----- hdl/fcba_pkg.sv -----
package fcba_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;

  localparam int unsigned IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned BMP_WORDS = (TABLE_ENTRIES + 15) / 16;
  localparam int unsigned BW_W      = (BMP_WORDS > 1) ? $clog2(BMP_WORDS) : 1;
  localparam int unsigned GROUPS    = (BMP_WORDS + 15) / 16;
  localparam int unsigned GW_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  localparam logic        OP_ALLOC  = 1'b0;
  localparam logic        OP_QUERY  = 1'b1;
  localparam logic [15:0] FREE_MARK = 16'h0000;
  localparam logic [15:0] END_MARK  = 16'hFFFF;

  typedef struct packed {
    logic        op;
    logic        has_predecessor;
    logic [11:0] block_index;
  } in_t;

  typedef struct packed {
    logic [15:0] block_value;
    logic        end_of_chain;
    logic        table_full;
  } out_t;

  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic tb_rd;
    logic link;
    logic bm_set;
    logic mark_new;
    logic scan_step;
    logic set_free;
    logic set_full;
    logic res_full;
    logic res_query;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_op;
    logic in_pred_ok;
    logic full;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/fcba_ctrl.sv -----
module fcba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fcba_pkg::sts_t sts_i,
  output fcba_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_Q_RD,
    ST_Q_RES,
    ST_A_LINK,
    ST_A_LSET,
    ST_A_MARK,
    ST_A_MSET,
    ST_A_SCAN,
    ST_A_FREE,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          if (sts_i.in_op == fcba_pkg::OP_QUERY) begin
            state_d = ST_Q_RD;
          end else if (sts_i.full) begin
            cmd_o.res_full = 1'b1;
            state_d        = ST_RESULT;
          end else if (sts_i.in_pred_ok) begin
            state_d = ST_A_LINK;
          end else begin
            state_d = ST_A_MARK;
          end
        end
      end
      ST_Q_RD: begin
        cmd_o.tb_rd = 1'b1;
        state_d     = ST_Q_RES;
      end
      ST_Q_RES: begin
        cmd_o.res_query = 1'b1;
        state_d         = ST_RESULT;
      end
      ST_A_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = ST_A_LSET;
      end
      ST_A_LSET: begin
        cmd_o.bm_set = 1'b1;
        state_d      = ST_A_MARK;
      end
      ST_A_MARK: begin
        cmd_o.mark_new = 1'b1;
        state_d        = ST_A_MSET;
      end
      ST_A_MSET: begin
        cmd_o.bm_set = 1'b1;
        state_d      = ST_A_SCAN;
      end
      ST_A_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = ST_A_FREE;
        end else if (sts_i.scan_last) begin
          cmd_o.set_full = 1'b1;
          state_d        = ST_RESULT;
        end
      end
      ST_A_FREE: begin
        cmd_o.set_free = 1'b1;
        state_d        = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/fcba_dpath.sv -----
module fcba_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fcba_pkg::in_t  in_data_i,
  input  logic           out_ready_i,
  input  fcba_pkg::cmd_t cmd_i,
  output fcba_pkg::sts_t sts_o,
  output logic           out_valid_o,
  output fcba_pkg::out_t out_data_o
);

  localparam int unsigned IDX_W  = fcba_pkg::IDX_W;
  localparam int unsigned BW_W   = fcba_pkg::BW_W;
  localparam int unsigned GW_W   = fcba_pkg::GW_W;
  localparam int unsigned GROUPS = fcba_pkg::GROUPS;

  function automatic logic [BW_W-1:0] word_of(input logic [IDX_W-1:0] p);
    return BW_W'(p >> 4);
  endfunction

  function automatic logic [15:0] bit_of(input logic [IDX_W-1:0] p);
    logic [3:0] b;
    b = 4'(p);
    return 16'd1 << b;
  endfunction

  function automatic logic [3:0] low_zero(input logic [15:0] v);
    logic [3:0] pos;
    pos = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (!v[i]) begin
        pos = 4'(i);
      end
    end
    return pos;
  endfunction

  function automatic logic [GROUPS-1:0][15:0] sum_init();
    logic [GROUPS-1:0][15:0] v;
    for (int g = 0; g < int'(GROUPS); g++) begin
      for (int b = 0; b < 16; b++) begin
        v[g][b] = ((g * 16 + b) >= int'(fcba_pkg::BMP_WORDS));
      end
    end
    return v;
  endfunction

  logic [15:0] table_mem [fcba_pkg::TABLE_ENTRIES];
  logic [15:0] bmp_mem [fcba_pkg::BMP_WORDS];

  logic [IDX_W-1:0]        clr_q;
  logic [IDX_W-1:0]        free_q;
  logic                    full_q;
  logic [GROUPS-1:0][15:0] sum_q;
  logic [GW_W-1:0]         scan_q;
  logic                    out_valid_q;

  fcba_pkg::in_t  in_q;
  fcba_pkg::out_t res_q;
  fcba_pkg::out_t out_q;
  logic [IDX_W-1:0] mark_q;
  logic [BW_W-1:0]  found_q;
  logic [15:0]      tb_rd_q;
  logic [15:0]      bm_rd_q;

  logic             idx_ok_in;
  logic             idx_ok_q;
  logic [IDX_W-1:0] q_ptr;
  logic [15:0]      grp_flags;
  logic             scan_hit;
  logic [BW_W-1:0]  found_w;
  logic [15:0]      bm_set_word;
  logic [15:0]      clr_pattern;
  logic             clr_bm;
  logic [BW_W-1:0]  bm_ra;
  logic             bm_re;
  logic             bm_we;
  logic [BW_W-1:0]  bm_wa;
  logic [15:0]      bm_wd;
  logic             tb_we;
  logic [IDX_W-1:0] tb_wa;
  logic [15:0]      tb_wd;
  logic [15:0]      q_value;
  logic [BW_W-1:0]  mark_word;

  assign idx_ok_in   = 17'(in_data_i.block_index) < 17'(fcba_pkg::TABLE_ENTRIES);
  assign idx_ok_q    = 17'(in_q.block_index) < 17'(fcba_pkg::TABLE_ENTRIES);
  assign q_ptr       = IDX_W'(in_q.block_index);
  assign grp_flags   = sum_q[scan_q];
  assign scan_hit    = ~&grp_flags;
  assign found_w     = BW_W'({scan_q, low_zero(grp_flags)});
  assign bm_set_word = bm_rd_q | bit_of(mark_q);
  assign mark_word   = word_of(mark_q);
  assign clr_bm      = 17'(clr_q) < 17'(fcba_pkg::BMP_WORDS);
  assign q_value     = idx_ok_q ? tb_rd_q : fcba_pkg::FREE_MARK;

  // padding bits past the last entry read as taken
  always_comb begin
    for (int b = 0; b < 16; b++) begin
      clr_pattern[b] = ((20'(clr_q) << 4) + 20'(b)) >= 20'(fcba_pkg::TABLE_ENTRIES);
    end
  end

  always_comb begin
    bm_re = cmd_i.link | cmd_i.mark_new | (cmd_i.scan_step & scan_hit);
    priority if (cmd_i.link) begin
      bm_ra = word_of(q_ptr);
    end else if (cmd_i.mark_new) begin
      bm_ra = word_of(free_q);
    end else begin
      bm_ra = found_w;
    end
  end

  always_comb begin
    bm_we = 1'b0;
    bm_wa = mark_word;
    bm_wd = bm_set_word;
    priority if (cmd_i.clr_step) begin
      bm_we = clr_bm;
      bm_wa = BW_W'(clr_q);
      bm_wd = clr_pattern;
    end else if (cmd_i.bm_set) begin
      bm_we = 1'b1;
    end
  end

  always_comb begin
    tb_we = 1'b0;
    tb_wa = free_q;
    tb_wd = fcba_pkg::END_MARK;
    priority if (cmd_i.clr_step) begin
      tb_we = 1'b1;
      tb_wa = clr_q;
      tb_wd = fcba_pkg::FREE_MARK;
    end else if (cmd_i.link) begin
      tb_we = 1'b1;
      tb_wa = q_ptr;
      tb_wd = 16'(free_q);
    end else if (cmd_i.mark_new) begin
      tb_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tb_we) begin
      table_mem[tb_wa] <= tb_wd;
    end
    if (cmd_i.tb_rd) begin
      tb_rd_q <= table_mem[q_ptr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bmp_mem[bm_wa] <= bm_wd;
    end
    if (bm_re) begin
      bm_rd_q <= bmp_mem[bm_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      free_q      <= '0;
      full_q      <= 1'b0;
      sum_q       <= sum_init();
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.bm_set && (&bm_set_word)) begin
        sum_q[GW_W'(mark_word >> 4)][4'(mark_word)] <= 1'b1;
      end
      if (cmd_i.mark_new) begin
        scan_q <= GW_W'(word_of(free_q) >> 4);
      end else if (cmd_i.scan_step && !scan_hit) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.set_free) begin
        free_q <= IDX_W'({found_q, low_zero(bm_rd_q)});
      end
      if (cmd_i.set_full) begin
        full_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.link) begin
      mark_q <= q_ptr;
    end else if (cmd_i.mark_new) begin
      mark_q <= free_q;
    end
    if (cmd_i.scan_step) begin
      found_q <= found_w;
    end
    priority if (cmd_i.res_full) begin
      res_q <= '{block_value: 16'd0, end_of_chain: 1'b0, table_full: 1'b1};
    end else if (cmd_i.mark_new) begin
      res_q <= '{block_value: 16'(free_q), end_of_chain: 1'b0, table_full: 1'b0};
    end else if (cmd_i.res_query) begin
      res_q <= '{block_value: q_value,
                 end_of_chain: (q_value == fcba_pkg::END_MARK),
                 table_full: 1'b0};
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign sts_o.clr_done   = (clr_q == IDX_W'(fcba_pkg::TABLE_ENTRIES - 1));
  assign sts_o.in_op      = in_data_i.op;
  // a link to block 0 leaves the free predecessor entry free
  assign sts_o.in_pred_ok = in_data_i.has_predecessor & idx_ok_in & (free_q != '0);
  assign sts_o.full       = full_q;
  assign sts_o.scan_hit   = scan_hit;
  assign sts_o.scan_last  = (scan_q == GW_W'(GROUPS - 1));
  assign sts_o.out_free   = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/fat_chain_block_allocator_core.sv -----
// query: the table entry is read and the result word formed, then loaded into the
// output register; allocate: the predecessor entry is linked (with a link), the new
// block is marked, then the free-summary scan of one 16-flag group per cycle finds
// the next free block; allocate on a full table: the result word is formed at accept
// one word in flight at a time; the output register lets a new word in while a result waits
// after reset the table is swept clear before the first word is taken
module fat_chain_block_allocator_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fcba_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fcba_pkg::out_t out_data_o
);

  fcba_pkg::cmd_t cmd;
  fcba_pkg::sts_t sts;

  fcba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fcba_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- dv/tb_fat_chain_block_allocator_core.sv -----
module tb_fat_chain_block_allocator_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SWAP_AT     = 290;
  localparam int unsigned CALM_AT     = 580;
  localparam int unsigned RAND_WORDS  = 850;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fcba_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fcba_pkg::out_t out_data;

  fcba_pkg::in_t  word_q[$];
  fcba_pkg::out_t result_q[$];
  logic [15:0] fat_tbl [2][fcba_pkg::TABLE_ENTRIES];
  int unsigned free_hint [2];

  int unsigned accepted = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit hold_off = 1'b0;
  fcba_pkg::out_t want;

  fat_chain_block_allocator_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // copy 0 tracks accepted words, copy 1 plans the stimulus ahead of time
  function automatic fcba_pkg::out_t fat_apply(input int unsigned cp, input fcba_pkg::in_t w);
    fcba_pkg::out_t r;
    int unsigned nb;
    r = '0;
    if (w.op == fcba_pkg::OP_QUERY) begin
      if (w.block_index < fcba_pkg::TABLE_ENTRIES) begin
        r.block_value = fat_tbl[cp][w.block_index];
      end
      r.end_of_chain = (r.block_value == fcba_pkg::END_MARK);
      return r;
    end
    nb = free_hint[cp];
    while (nb < fcba_pkg::TABLE_ENTRIES && fat_tbl[cp][nb] != fcba_pkg::FREE_MARK) nb++;
    free_hint[cp] = nb;
    if (nb >= fcba_pkg::TABLE_ENTRIES) begin
      r.table_full = 1'b1;
      return r;
    end
    if (w.has_predecessor && w.block_index < fcba_pkg::TABLE_ENTRIES) begin
      fat_tbl[cp][w.block_index] = nb[15:0];
    end
    fat_tbl[cp][nb] = fcba_pkg::END_MARK;
    r.block_value = nb[15:0];
    return r;
  endfunction

  function automatic fcba_pkg::in_t mk_word(input logic op, input logic hp,
                                            input int unsigned idx);
    fcba_pkg::in_t w;
    w.op = op;
    w.has_predecessor = hp;
    w.block_index = idx[11:0];
    return w;
  endfunction

  function automatic fcba_pkg::out_t plan_word(input fcba_pkg::in_t w);
    word_q.push_back(w);
    return fat_apply(1, w);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic drain_wait();
    while (word_q.size() != 0 || in_valid || result_q.size() != 0) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    int unsigned idle_pct;
    if (rst_n) begin
      idle_pct = (accepted < SWAP_AT) ? 16 : (accepted < CALM_AT) ? 61 : 0;
      if (in_valid && in_ready) begin
        result_q.push_back(fat_apply(0, in_data));
        accepted <= accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data <= word_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    int unsigned idle_pct;
    if (rst_n) begin
      idle_pct = (accepted < SWAP_AT) ? 61 : (accepted < CALM_AT) ? 16 : 0;
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_data));
        end else begin
          want = result_q.pop_front();
          if (out_data.block_value != want.block_value)
            report_mismatch($sformatf("block_value %h, want %h",
                                      out_data.block_value, want.block_value));
          if (out_data.end_of_chain != want.end_of_chain)
            report_mismatch($sformatf("end_of_chain %b, want %b",
                                      out_data.end_of_chain, want.end_of_chain));
          if (out_data.table_full != want.table_full)
            report_mismatch($sformatf("table_full %b, want %b",
                                      out_data.table_full, want.table_full));
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // long receiver stall so the input side backs up
  initial begin
    wait (accepted >= 150);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (400) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    int unsigned tails[$];
    int unsigned used[$];
    int unsigned pick;
    int unsigned idx;
    fcba_pkg::out_t r;
    fcba_pkg::in_t w;

    for (int i = 0; i < fcba_pkg::TABLE_ENTRIES; i++) begin
      fat_tbl[0][i] = fcba_pkg::FREE_MARK;
      fat_tbl[1][i] = fcba_pkg::FREE_MARK;
    end
    free_hint[0] = 0;
    free_hint[1] = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'b0, 0)));
    void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'b1, 4095)));
    void'(plan_word(mk_word(fcba_pkg::OP_ALLOC, 1'b1, 5)));
    void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'b0, 5)));
    void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'b0, 0)));
    void'(plan_word(mk_word(fcba_pkg::OP_ALLOC, 1'b1, 1)));
    void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'b0, 1)));
    void'(plan_word(mk_word(fcba_pkg::OP_ALLOC, 1'b0, 4095)));
    void'(plan_word(mk_word(fcba_pkg::OP_ALLOC, 1'b1, 2)));
    void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'b0, 2)));
    void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'b0, 3)));
    void'(plan_word(mk_word(fcba_pkg::OP_ALLOC, 1'b1, 4095)));
    void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'b0, 4095)));
    void'(plan_word(mk_word(fcba_pkg::OP_ALLOC, 1'b1, 0)));
    void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'b0, 0)));
    void'(plan_word(mk_word(fcba_pkg::OP_ALLOC, 1'b0, 0)));
    void'(plan_word(mk_word(fcba_pkg::OP_ALLOC, 1'b1, 4094)));
    void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'b0, 4094)));
    void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'b1, 2048)));
    void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'b0, 7)));
    drain_wait();

    // random: mostly chain building and chain walks, some noise
    @(negedge clk);
    for (int n = 0; n < RAND_WORDS; n++) begin
      pick = $urandom_range(99);
      if (pick < 45 && tails.size() != 0) begin
        idx = $urandom_range(tails.size() - 1);
        r = plan_word(mk_word(fcba_pkg::OP_ALLOC, 1'b1, tails[idx]));
        tails[idx] = r.block_value;
        used.push_back(r.block_value);
      end else if (pick < 55 || (pick < 80 && used.size() == 0)) begin
        r = plan_word(mk_word(fcba_pkg::OP_ALLOC, 1'b0, $urandom_range(4095)));
        tails.push_back(r.block_value);
        used.push_back(r.block_value);
        if (tails.size() > 6) tails.delete($urandom_range(tails.size() - 1));
      end else if (pick < 80) begin
        idx = used[$urandom_range(used.size() - 1)];
        void'(plan_word(mk_word(fcba_pkg::OP_QUERY, 1'($urandom_range(1)), idx)));
      end else begin
        w = fcba_pkg::in_t'(14'($urandom_range(16383)));
        r = plan_word(w);
        if (w.op == fcba_pkg::OP_ALLOC) used.push_back(r.block_value);
      end
    end
    drain_wait();

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
